// ----- rtl/esg_pkg.sv -----
// Shared types, constants and the quarter-wave sine function for the exponential sweep generator.
`default_nettype none

package esg_pkg;

    localparam int ENV_W       = 56;
    localparam int FRAC_W      = 46;
    localparam int RATIO_W     = 47;
    localparam int PHASE_W     = 32;
    localparam int AMP_W       = 16;
    localparam int AMP_FRAC    = 15;
    localparam int COUNT_W     = 32;
    localparam int TURN_W      = 32;
    localparam int PHASE_SHIFT = 30;
    localparam int MAG_W       = 31;

    localparam int MUL_A_W  = 57;
    localparam int MUL_B_W  = 48;
    localparam int MUL_CH_W = 24;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;

    localparam logic [ENV_W-1:0]   ENV_ONE   = 56'h4000_0000_0000;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 47'h4000_0000_0000;
    localparam logic [AMP_W-1:0]   AMP_RESET = 16'h8000;
    localparam logic [COUNT_W-1:0] LEN_RESET = 32'd48000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'h4000_0000;

    typedef enum logic [2:0] {
        REG_GROWTH      = 3'd0,
        REG_SQRT_GROWTH = 3'd1,
        REG_PHASE_SCALE = 3'd2,
        REG_AMP_SCALE   = 3'd3,
        REG_LENGTH      = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [RATIO_W-1:0] growth_ratio;
        logic [RATIO_W-1:0] sqrt_growth_ratio;
        logic [PHASE_W-1:0] phase_scale;
        logic [AMP_W-1:0]   amplitude_scale;
        logic [COUNT_W-1:0] length_samples;
    } t_cfg;

    typedef struct packed {
        logic restart;
    } t_item;

    typedef struct packed {
        logic               start;
        logic               two;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    // Quarter-wave sine in Q1.30 by a truncated Taylor series, clamped to [0, 1.0].
    function automatic logic [MAG_W-1:0] sine_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [65:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed({2'b00, x});
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k[0]) begin
                sum = sum - $signed({2'b00, term});
            end else begin
                sum = sum + $signed({2'b00, term});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed({2'b00, Q30_ONE})) begin
            sum = $signed({2'b00, Q30_ONE});
        end
        return sum[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/esg_mul.sv -----
// Shared multiplier that builds a wide product from one or two 57 by 24 bit partial products.
`default_nettype none

module esg_mul
    import esg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mul_req          i_req,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_prod
);

    localparam int PP_W = MUL_A_W + MUL_CH_W;

    logic [MUL_A_W-1:0]  r_a;
    logic [MUL_CH_W-1:0] r_bh;
    logic                r_ph2;
    logic                r_done;
    logic [PROD_W-1:0]   r_acc;

    logic [MUL_A_W-1:0]  w_ma;
    logic [MUL_CH_W-1:0] w_mb;
    logic [PP_W-1:0]     w_pp;

    assign w_ma = i_req.start ? i_req.a : r_a;
    assign w_mb = i_req.start ? i_req.b[MUL_CH_W-1:0] : r_bh;
    assign w_pp = PP_W'(w_ma) * PP_W'(w_mb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph2  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ph2  <= i_req.start && i_req.two;
            r_done <= (i_req.start && !i_req.two) || r_ph2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_bh  <= i_req.b[MUL_B_W-1:MUL_CH_W];
            r_acc <= PROD_W'(w_pp);
        end else if (r_ph2) begin
            r_acc <= r_acc + (PROD_W'(w_pp) << MUL_CH_W);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ----- rtl/esg_front.sv -----
// Input side that accepts sample requests into a two-entry queue.
`default_nettype none

module esg_front
    import esg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_tvalid,
    output logic      o_tready,
    input  wire logic i_restart,
    output logic      o_item_valid,
    output t_item     o_item,
    input  wire logic i_pop
);

    localparam logic [1:0] DEPTH = 2'd2;

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;

    assign o_tready     = (r_count != DEPTH);
    assign w_push       = i_tvalid && o_tready;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (w_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!w_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr].restart <= i_restart;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/esg_regs.sv -----
// Configuration register file behind the APB port.
`default_nettype none

module esg_regs
    import esg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:3]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.growth_ratio      <= RATIO_ONE;
            r_cfg.sqrt_growth_ratio <= RATIO_ONE;
            r_cfg.phase_scale       <= '0;
            r_cfg.amplitude_scale   <= AMP_RESET;
            r_cfg.length_samples    <= LEN_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GROWTH:      r_cfg.growth_ratio      <= pwdata[RATIO_W-1:0];
                REG_SQRT_GROWTH: r_cfg.sqrt_growth_ratio <= pwdata[RATIO_W-1:0];
                REG_PHASE_SCALE: r_cfg.phase_scale       <= pwdata[PHASE_W-1:0];
                REG_AMP_SCALE:   r_cfg.amplitude_scale   <= pwdata[AMP_W-1:0];
                REG_LENGTH:      r_cfg.length_samples    <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_GROWTH:      prdata = CFG_DATA_W'(r_cfg.growth_ratio);
            REG_SQRT_GROWTH: prdata = CFG_DATA_W'(r_cfg.sqrt_growth_ratio);
            REG_PHASE_SCALE: prdata = CFG_DATA_W'(r_cfg.phase_scale);
            REG_AMP_SCALE:   prdata = CFG_DATA_W'(r_cfg.amplitude_scale);
            REG_LENGTH:      prdata = CFG_DATA_W'(r_cfg.length_samples);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/esg_core.sv -----
// Sequencer that updates the sweep state and forms one sample per request.
`default_nettype none

module esg_core
    import esg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_WIDTH     = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_item_valid,
    input  wire t_item                   i_item,
    output logic                         o_pop,
    output logic                         o_out_valid,
    output logic [SAMPLE_WIDTH-1:0]      o_out_sample,
    output logic                         o_out_end,
    input  wire logic                    i_out_ready
);

    localparam int LOG2D = $clog2(SINE_TABLE_DEPTH);
    localparam int PW    = LOG2D + 2;
    localparam int AW    = LOG2D + 1;
    localparam int ROM_N = SINE_TABLE_DEPTH + 1;
    localparam int VS    = 77 - SAMPLE_WIDTH;
    localparam int VW    = PROD_W - VS;

    typedef logic [MAG_W-1:0] t_rom [ROM_N];

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] x;
        for (int i = 0; i < ROM_N; i++) begin
            x      = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
            rom[i] = sine_q30(x);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    typedef enum logic [3:0] {
        S_IDLE,
        S_E_START,
        S_E_WAIT,
        S_S_WAIT,
        S_P_WAIT,
        S_A_WAIT,
        S_V_START,
        S_V_WAIT,
        S_FIN
    } t_state;

    t_state                  r_state;
    logic [ENV_W-1:0]        r_exp;
    logic [ENV_W-1:0]        r_sqrt;
    logic [COUNT_W-1:0]      r_count;
    logic [ENV_W-1:0]        r_d;
    logic                    r_neg;
    logic [TURN_W-1:0]       r_turn;
    logic [MAG_W-1:0]        r_rom;
    logic                    r_qneg;
    logic [SAMPLE_WIDTH-1:0] r_res;
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                    r_out_end;

    t_mul_req                w_req;
    logic                    w_done;
    logic [PROD_W-1:0]       w_prod;

    logic [ENV_W-1:0]        w_env_sat;
    logic [TURN_W-1:0]       w_turn_raw;
    logic [PW-1:0]           w_p;
    logic [1:0]              w_q;
    logic [LOG2D-1:0]        w_r;
    logic [AW-1:0]           w_addr;
    logic [VW-1:0]           w_val;
    logic [VW-1:0]           w_limit;
    logic [SAMPLE_WIDTH-1:0] w_mag;
    logic                    w_out_free;
    logic                    w_fin;

    esg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    always_comb begin
        w_req.start = 1'b0;
        w_req.two   = 1'b1;
        w_req.a     = '0;
        w_req.b     = '0;
        unique case (r_state)
            S_E_START: begin
                w_req.start = 1'b1;
                w_req.a     = MUL_A_W'(r_exp);
                w_req.b     = MUL_B_W'(i_cfg.growth_ratio);
            end
            S_E_WAIT: begin
                w_req.start = w_done;
                w_req.a     = MUL_A_W'(r_sqrt);
                w_req.b     = MUL_B_W'(i_cfg.sqrt_growth_ratio);
            end
            S_S_WAIT: begin
                w_req.start = w_done;
                w_req.a     = MUL_A_W'(r_d);
                w_req.b     = MUL_B_W'(i_cfg.phase_scale);
            end
            S_P_WAIT: begin
                w_req.start = w_done;
                w_req.two   = 1'b0;
                w_req.a     = MUL_A_W'(r_sqrt);
                w_req.b     = MUL_B_W'(i_cfg.amplitude_scale);
            end
            S_V_START: begin
                w_req.start = 1'b1;
                w_req.a     = w_prod[AMP_FRAC+MUL_A_W-1:AMP_FRAC];
                w_req.b     = MUL_B_W'(r_rom);
            end
            default: ;
        endcase
    end

    assign w_env_sat  = (|w_prod[PROD_W-1:FRAC_W+ENV_W]) ? '1
                                                          : w_prod[FRAC_W+ENV_W-1:FRAC_W];
    assign w_turn_raw = w_prod[PHASE_SHIFT+TURN_W-1:PHASE_SHIFT];

    assign w_p    = r_turn[TURN_W-1 -: PW];
    assign w_q    = w_p[PW-1 -: 2];
    assign w_r    = w_p[LOG2D-1:0];
    assign w_addr = w_q[0] ? (AW'(SINE_TABLE_DEPTH) - {1'b0, w_r}) : {1'b0, w_r};

    assign w_val   = w_prod[PROD_W-1:VS];
    assign w_limit = r_qneg ? (VW'(1) << (SAMPLE_WIDTH - 1))
                            : ((VW'(1) << (SAMPLE_WIDTH - 1)) - VW'(1));
    assign w_mag   = (w_val > w_limit) ? w_limit[SAMPLE_WIDTH-1:0] : w_val[SAMPLE_WIDTH-1:0];

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fin      = (r_state == S_FIN) && w_out_free;
    assign o_pop      = (r_state == S_IDLE) && i_item_valid;

    always_ff @(posedge i_clk) begin
        r_rom  <= SINE_ROM[w_addr];
        r_qneg <= w_q[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp       <= ENV_ONE;
            r_sqrt      <= ENV_ONE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        if (i_item.restart) begin
                            r_exp   <= ENV_ONE;
                            r_sqrt  <= ENV_ONE;
                            r_count <= COUNT_W'(1);
                        end else begin
                            r_count <= r_count + COUNT_W'(1);
                        end
                        r_state <= S_E_START;
                    end
                end
                S_E_START: begin
                    r_state <= S_E_WAIT;
                end
                S_E_WAIT: begin
                    if (w_done) begin
                        r_exp   <= w_env_sat;
                        r_state <= S_S_WAIT;
                    end
                end
                S_S_WAIT: begin
                    r_neg <= (r_exp < ENV_ONE);
                    r_d   <= (r_exp < ENV_ONE) ? (ENV_ONE - r_exp) : (r_exp - ENV_ONE);
                    if (w_done) begin
                        r_sqrt  <= w_env_sat;
                        r_state <= S_P_WAIT;
                    end
                end
                S_P_WAIT: begin
                    if (w_done) begin
                        r_turn  <= r_neg ? (TURN_W'(0) - w_turn_raw) : w_turn_raw;
                        r_state <= S_A_WAIT;
                    end
                end
                S_A_WAIT: begin
                    if (w_done) begin
                        r_state <= S_V_START;
                    end
                end
                S_V_START: begin
                    r_state <= S_V_WAIT;
                end
                S_V_WAIT: begin
                    if (w_done) begin
                        r_res   <= r_qneg ? (SAMPLE_WIDTH'(0) - w_mag) : w_mag;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_res;
                        r_out_end    <= (r_count > i_cfg.length_samples);
                        if (r_count > i_cfg.length_samples) begin
                            r_exp   <= ENV_ONE;
                            r_sqrt  <= ENV_ONE;
                            r_count <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_out_end    = r_out_end;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> (r_count <= i_cfg.length_samples))
        else $error("Sample count exceeds the sweep length after a sample was finished.");

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_E_WAIT || r_state == S_S_WAIT || r_state == S_P_WAIT ||
                    r_state == S_A_WAIT || r_state == S_V_WAIT))
        else $error("Multiplier finished while the sequencer was not waiting for it.");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("Output became valid without a finished sample.");

endmodule

`default_nettype wire

// ----- rtl/exponential_sweep_generator_unit.sv -----
// Top level of the exponential sine sweep generator.
// The five products of each sample share one 57 by 24 bit multiplier.
// A two-entry request queue keeps accepting until full while a sample is being made or waits on output.
// Reset is synchronous and active low; it loads the register defaults and the sweep start.
// The sine table is a constant ROM, so no clearing pass follows reset.
`default_nettype none

module exponential_sweep_generator_unit
    import esg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_WIDTH     = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // bit 0: restart
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata, // sample from bit 0
    output logic                       m_axis_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    t_cfg                    w_cfg;
    logic                    w_item_valid;
    t_item                   w_item;
    logic                    w_pop;
    logic [SAMPLE_WIDTH-1:0] w_sample;

    esg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    esg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_restart    (s_axis_tdata[0]),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    esg_core #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_WIDTH     (SAMPLE_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_out_valid  (m_axis_tvalid),
        .o_out_sample (w_sample),
        .o_out_end    (m_axis_tlast),
        .i_out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = OUT_W'(w_sample);

endmodule

`default_nettype wire
